// ----- hw/rtl/mbp_pkg.sv -----
package mbp_pkg;

  localparam int LowRamBytesDef = 1024;
  localparam int RxFifoDepthDef = 16;
  localparam int PagedBytes = 4096;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_PUSH  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    GRP_UART  = 2'd0,
    GRP_GPIO  = 2'd1,
    GRP_TIMER = 2'd2,
    GRP_NONE  = 2'd3
  } grp_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  localparam logic [16:0] TimerStop = 17'h10000;
  localparam logic [16:0] TimerAll  = 17'h1ffff;
  localparam logic [15:0] WinMask   = 16'hffe0;
  localparam logic [15:0] PagedBase = 16'h0800;
  localparam logic [15:0] PagedEnd  = 16'h1800;
  localparam logic [7:0]  HighMark  = 8'h80;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [15:0] tick_count;
    logic [14:0] pins_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
    logic       rx_overflow;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic execute;
    logic finish;
  } ctl_t;

endpackage

// ----- hw/rtl/mbp_ctrl.sv -----
module mbp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output mbp_pkg::ctl_t ctl
);
  import mbp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = 1'b0;
    done = 1'b0;
    case (state)
      ST_IDLE: ctl.capture = start;
      ST_EXEC: begin
        busy = 1'b1;
        ctl.execute = 1'b1;
      end
      ST_DONE: begin
        busy = 1'b1;
        done = 1'b1;
        ctl.finish = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  ap_exec_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ctl.execute) else $error("no execute after start");
  ap_done_follows: assert property (@(posedge clk) disable iff (rst)
    ctl.execute |=> done) else $error("done missing");
  ap_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done repeated");
endmodule

// ----- hw/rtl/mbp_datapath.sv -----
module mbp_datapath #(
  parameter int LOW_RAM_BYTES = mbp_pkg::LowRamBytesDef,
  parameter int RX_FIFO_DEPTH = mbp_pkg::RxFifoDepthDef
) (
  input  logic               clk,
  input  logic               rst,
  input  mbp_pkg::ctl_t      ctl,
  input  mbp_pkg::in_item_t  item,
  input  logic               quiet_tx,
  output mbp_pkg::out_item_t result
);
  import mbp_pkg::*;

  localparam int LAW = (LOW_RAM_BYTES > 1) ? $clog2(LOW_RAM_BYTES) : 1;
  localparam int PAW = $clog2(PagedBytes);
  localparam int RAW = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
  localparam int RFW = $clog2(RX_FIFO_DEPTH + 1);

  logic [7:0] low_ram [LOW_RAM_BYTES];
  logic [7:0] paged_ram [PagedBytes];
  logic [7:0] rx_store [RX_FIFO_DEPTH];

  in_item_t    cur;
  logic [14:0] gpio_output, gpio_direction;
  logic [16:0] timer_count;
  logic        timer_flag;
  logic [RAW-1:0] rx_head, rx_tail;
  logic [RFW-1:0] rx_fill;

  // Registered memory reads: low_q and paged_q are taken in the capture cycle, rx_q every cycle.
  logic [7:0] low_q, paged_q, rx_q;

  logic        in_win, in_low, in_paged, odd;
  logic [1:0]  grp, off;
  logic [14:0] eff;
  logic [7:0]  rd;
  logic        txv, ovf, pop, flag_next;
  logic [16:0] tc_next;
  logic [15:0] paddr_off;
  logic [15:0] cur_poff;
  logic [16:0] nt;

  always_comb begin
    in_win = (cur.addr & WinMask) == WinMask;
    grp = cur.addr[4:3];
    off = cur.addr[1:0];
    odd = cur.addr[0];
    in_low = {1'b0, cur.addr} < 17'(LOW_RAM_BYTES);
    in_paged = cur.addr >= PagedBase && cur.addr < PagedEnd;
    eff = (gpio_output & gpio_direction) | (cur.pins_in & ~gpio_direction);
    nt = {1'b0, cur.tick_count};
    rd = '0;
    txv = 1'b0;
    ovf = 1'b0;
    pop = 1'b0;
    flag_next = timer_flag;
    tc_next = timer_count;
    case (cur.cmd)
      CMD_READ: begin
        if (in_win) begin
          case (grp)
            GRP_UART: begin
              if (!odd) begin
                rd = {7'd0, rx_fill != '0};
              end else if (rx_fill != '0) begin
                rd = rx_q;
                pop = 1'b1;
              end
            end
            GRP_GPIO: begin
              case (off)
                2'd0: rd = HighMark | {1'b0, eff[14:8]};
                2'd1: rd = eff[7:0];
                2'd2: rd = HighMark | {1'b0, gpio_direction[14:8]};
                default: rd = gpio_direction[7:0];
              endcase
            end
            GRP_TIMER: begin
              case (off)
                2'd0: rd = timer_count[7:0];
                2'd1: rd = timer_count[15:8];
                default: rd = {5'd0, timer_count[16], 1'b0, timer_flag};
              endcase
              if (off[1]) flag_next = 1'b0;
            end
            default: rd = '0;
          endcase
        end else if (in_low) begin
          rd = low_q;
        end else if (in_paged) begin
          rd = paged_q;
        end
      end
      CMD_WRITE: begin
        if (in_win) begin
          if (grp == GRP_UART) txv = odd && !quiet_tx;
          if (grp == GRP_TIMER) begin
            case (off)
              2'd0: tc_next = {timer_count[16:8], cur.wdata};
              2'd1: tc_next = {1'b0, cur.wdata, timer_count[7:0]};
              default: flag_next = 1'b0;
            endcase
          end
        end
      end
      CMD_TICK: begin
        if (!timer_count[16] && nt != '0) begin
          if (timer_count != '0 && nt >= timer_count) flag_next = !timer_flag;
          tc_next = (nt > timer_count) ? TimerAll : timer_count - nt;
        end
      end
      default: ovf = rx_fill >= RFW'(RX_FIFO_DEPTH);
    endcase
  end

  assign paddr_off = item.addr - PagedBase;
  assign cur_poff = cur.addr - PagedBase;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cur <= item;
      low_q <= low_ram[item.addr[LAW-1:0]];
      paged_q <= paged_ram[paddr_off[PAW-1:0]];
    end
    rx_q <= rx_store[rx_head];
    if (ctl.execute && cur.cmd == CMD_WRITE && !in_win) begin
      if (in_low) low_ram[cur.addr[LAW-1:0]] <= cur.wdata;
      if (in_paged) paged_ram[cur_poff[PAW-1:0]] <= cur.wdata;
    end
    if (ctl.execute && cur.cmd == CMD_PUSH && !ovf) rx_store[rx_tail] <= cur.wdata;
    if (ctl.execute) begin
      result.read_data <= rd;
      result.tx_valid <= txv;
      result.tx_byte <= txv ? cur.wdata : 8'd0;
      result.irq <= flag_next;
      result.rx_overflow <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gpio_output <= '0;
      gpio_direction <= '0;
      timer_count <= TimerStop;
      timer_flag <= 1'b0;
      rx_head <= '0;
      rx_tail <= '0;
      rx_fill <= '0;
    end else if (ctl.execute) begin
      timer_count <= tc_next;
      timer_flag <= flag_next;
      if (cur.cmd == CMD_WRITE && in_win && grp == GRP_GPIO) begin
        case (off)
          2'd0: gpio_output[14:8] <= cur.wdata[6:0];
          2'd1: gpio_output[7:0] <= cur.wdata;
          2'd2: gpio_direction[14:8] <= cur.wdata[6:0];
          default: gpio_direction[7:0] <= cur.wdata;
        endcase
      end
      if (pop) begin
        rx_head <= (32'(rx_head) == RX_FIFO_DEPTH - 1) ? '0 : rx_head + 1'b1;
        rx_fill <= rx_fill - 1'b1;
      end
      if (cur.cmd == CMD_PUSH && !ovf) begin
        rx_tail <= (32'(rx_tail) == RX_FIFO_DEPTH - 1) ? '0 : rx_tail + 1'b1;
        rx_fill <= rx_fill + 1'b1;
      end
    end
  end

  ap_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rx_fill <= RFW'(RX_FIFO_DEPTH)) else $error("fifo fill overrun");
  ap_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (rx_fill == '0) |-> (rx_head == rx_tail)) else $error("fifo pointers disagree");
  ap_stop_all: assert property (@(posedge clk) disable iff (rst)
    (ctl.execute && cur.cmd == CMD_TICK && timer_count[16]) |=> $stable(timer_count))
    else $error("stopped timer moved");
endmodule

// ----- hw/rtl/mcu_bus_peripherals_unit.sv -----
// A transaction accepted on start is captured in idle, then passes the execute and done
// states; its result is shown with done. A new start is taken only once back in idle:
// busy covers the execute and result states, and the RAM read is registered at capture.
// Reset (synchronous rst) stops the timer at 0x10000, clears GPIO, flag and FIFO pointers.
// RAM contents are not cleared. The receiver cannot stall: done lasts one cycle.
module mcu_bus_peripherals_unit #(
  parameter int LOW_RAM_BYTES = mbp_pkg::LowRamBytesDef,
  parameter int RX_FIFO_DEPTH = mbp_pkg::RxFifoDepthDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mbp_pkg::in_item_t  item,
  output logic               done,
  output mbp_pkg::out_item_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mbp_pkg::*;

  ctl_t ctl;
  logic quiet_tx;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {31'd0, quiet_tx} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_tx <= 1'b0;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      quiet_tx <= pwdata[0];
    end
  end

  mbp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .ctl(ctl)
  );

  mbp_datapath #(.LOW_RAM_BYTES(LOW_RAM_BYTES), .RX_FIFO_DEPTH(RX_FIFO_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .item(item), .quiet_tx(quiet_tx), .result(result)
  );
endmodule
